>>> hdl/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Shared types, codes and the bus phase table of the i2c master bit engine.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  // command codes of an input transaction
  localparam logic [2:0] CMD_TICK  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  // register index, taken from the word address bit
  localparam logic REG_PHASE_TICKS = 1'b0;

  localparam logic [7:0] PHASE_TICKS_RST = 8'd4;
  localparam logic [3:0] BYTE_BITS       = 4'd8;
  localparam logic [2:0] LAST_STEP       = 3'd5;

  // running sequence, one-hot
  typedef enum logic [4:0] {
    OP_IDLE  = 5'b00001,
    OP_START = 5'b00010,
    OP_STOP  = 5'b00100,
    OP_WRITE = 5'b01000,
    OP_READ  = 5'b10000
  } op_t;

  // driven bus lines
  typedef struct packed {
    logic en;
    logic sda;
    logic scl;
  } lines_t;

  localparam lines_t LINES_RELEASED = '{en: 1'b0, sda: 1'b1, scl: 1'b1};

  // engine state carried from tick to tick
  typedef struct packed {
    op_t        op;
    logic [2:0] step;
    logic [3:0] bits;
    logic [7:0] hold;
    logic [7:0] shift;
    lines_t     lines;
    logic       ack;
    logic [7:0] rd;
  } eng_state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_seen;
  } out_item_t;

  // scl/sda levels of each phase of each sequence
  function automatic lines_t lines_for(op_t op, logic [2:0] step, logic data);
    lines_t l;
    l = LINES_RELEASED;
    unique case (op)
      OP_START: begin
        if (step == 3'd0)      l = '{en: 1'b1, sda: 1'b1, scl: 1'b1};
        else if (step == 3'd1) l = '{en: 1'b1, sda: 1'b0, scl: 1'b1};
        else                   l = '{en: 1'b1, sda: 1'b0, scl: 1'b0};
      end
      OP_STOP: begin
        if (step == 3'd0)      l = '{en: 1'b1, sda: 1'b0, scl: 1'b0};
        else if (step == 3'd1) l = '{en: 1'b1, sda: 1'b0, scl: 1'b1};
        else                   l = '{en: 1'b1, sda: 1'b1, scl: 1'b1};
      end
      OP_WRITE: begin
        if (step == 3'd0)      l = '{en: 1'b1, sda: data, scl: 1'b0};
        else if (step == 3'd1) l = '{en: 1'b1, sda: data, scl: 1'b1};
        else if (step == 3'd2) l = '{en: 1'b1, sda: data, scl: 1'b0};
        else if (step == 3'd4) l = '{en: 1'b0, sda: 1'b1, scl: 1'b1};
        else                   l = '{en: 1'b1, sda: 1'b0, scl: 1'b0};
      end
      OP_READ: begin
        if (step == 3'd1)                      l = '{en: 1'b0, sda: 1'b1, scl: 1'b1};
        else if (step == 3'd0 || step == 3'd2) l = '{en: 1'b0, sda: 1'b1, scl: 1'b0};
        else if (step == 3'd4)                 l = '{en: 1'b1, sda: 1'b0, scl: 1'b1};
        else                                   l = '{en: 1'b1, sda: 1'b0, scl: 1'b0};
      end
      default: l = LINES_RELEASED;
    endcase
    return l;
  endfunction

endpackage

>>> hdl/i2cbe_phase.sv
// ----------------------------------------------------------------------------
// i2cbe_phase
// Next-state logic for one tick: command launch, phase hold count, bit
// shifting, acknowledge sampling, and the result fields after the tick.
// ----------------------------------------------------------------------------
module i2cbe_phase (
  input  i2cbe_pkg::eng_state_t cur,
  input  i2cbe_pkg::in_item_t   item,
  input  logic [7:0]            phase_ticks,
  output i2cbe_pkg::eng_state_t nxt,
  output i2cbe_pkg::out_item_t  res
);

  logic [7:0] limit;
  logic       done;
  logic       ent;
  logic [2:0] ent_step;
  logic [3:0] bits_inc;

  // zero ticks behaves as one
  assign limit    = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign bits_inc = cur.bits + 4'd1;

  always_comb begin
    nxt      = cur;
    done     = 1'b0;
    ent      = 1'b0;
    ent_step = 3'd0;

    // idle: launch a new sequence
    if (cur.op == i2cbe_pkg::OP_IDLE) begin
      ent = 1'b1;
      nxt.bits = 4'd0;
      unique case (item.cmd)
        i2cbe_pkg::CMD_START: nxt.op = i2cbe_pkg::OP_START;
        i2cbe_pkg::CMD_STOP:  nxt.op = i2cbe_pkg::OP_STOP;
        i2cbe_pkg::CMD_WRITE: begin
          nxt.op    = i2cbe_pkg::OP_WRITE;
          nxt.shift = item.write_byte;
        end
        i2cbe_pkg::CMD_READ: begin
          nxt.op    = i2cbe_pkg::OP_READ;
          nxt.shift = 8'd0;
        end
        default: begin
          ent      = 1'b0;
          nxt.bits = cur.bits;
        end
      endcase
    end else if (cur.hold >= limit) begin
      // phase over: move on
      unique case (cur.op)
        i2cbe_pkg::OP_WRITE: begin
          if (cur.step == 3'd2) begin
            nxt.shift = {cur.shift[6:0], 1'b0};
            nxt.bits  = bits_inc;
            ent       = 1'b1;
            ent_step  = (bits_inc < i2cbe_pkg::BYTE_BITS) ? 3'd0 : 3'd3;
          end else if (cur.step == 3'd4) begin
            nxt.ack  = ~item.sda_in;
            ent      = 1'b1;
            ent_step = 3'd5;
          end else if (cur.step >= i2cbe_pkg::LAST_STEP) begin
            done = 1'b1;
          end else begin
            ent      = 1'b1;
            ent_step = cur.step + 3'd1;
          end
        end
        i2cbe_pkg::OP_READ: begin
          if (cur.step == 3'd1) begin
            nxt.shift = {cur.shift[6:0], item.sda_in};
            nxt.bits  = bits_inc;
            ent       = 1'b1;
            ent_step  = 3'd2;
          end else if (cur.step == 3'd2) begin
            ent      = 1'b1;
            ent_step = (cur.bits < i2cbe_pkg::BYTE_BITS) ? 3'd1 : 3'd3;
          end else if (cur.step >= i2cbe_pkg::LAST_STEP) begin
            nxt.rd = cur.shift;
            done   = 1'b1;
          end else begin
            ent      = 1'b1;
            ent_step = cur.step + 3'd1;
          end
        end
        default: begin
          // start and stop walk three phases
          if (cur.step < 3'd2) begin
            ent      = 1'b1;
            ent_step = cur.step + 3'd1;
          end else begin
            done = 1'b1;
          end
        end
      endcase
    end else begin
      nxt.hold = cur.hold + 8'd1;
    end

    // enter a phase
    if (ent) begin
      nxt.step  = ent_step;
      nxt.hold  = 8'd1;
      nxt.lines = i2cbe_pkg::lines_for(nxt.op, ent_step, nxt.shift[7]);
    end

    // sequence finished
    if (done) begin
      if (cur.op == i2cbe_pkg::OP_STOP) nxt.lines = i2cbe_pkg::LINES_RELEASED;
      nxt.op   = i2cbe_pkg::OP_IDLE;
      nxt.step = 3'd0;
      nxt.hold = 8'd0;
    end
  end

  // result fields reflect the state after the tick
  always_comb begin
    res.scl_level  = nxt.lines.scl;
    res.sda_level  = nxt.lines.en ? nxt.lines.sda : 1'b1;
    res.sda_enable = nxt.lines.en;
    res.busy_res   = (nxt.op != i2cbe_pkg::OP_IDLE);
    res.done_res   = done;
    res.read_byte  = nxt.rd;
    res.ack_seen   = nxt.ack;
  end

endmodule

>>> hdl/i2c_master_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// Tick-driven i2c master line engine with an apb-style config port.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction (in_valid/in_stall, in_data) is one time tick with
//   an optional command (start, stop, write byte, read byte), the byte to
//   write and the sampled sda level. Commands are ignored while busy.
//   Every tick gives exactly one result transaction (out_valid/out_stall,
//   out_data) carrying the scl/sda drive, busy, done, last read byte and ack.
//   The result is registered on the edge that accepts the tick. Throughput is
//   one tick per cycle while the receiver does not stall, set by the single
//   pass of next-state logic between the state register and the result register.
//   A new tick is accepted while the result register is empty or is being
//   taken in the same cycle; when the receiver stalls with a result waiting,
//   in_stall is raised and the engine state holds.
//   The config port holds phase_ticks (byte address 0, reset 4), the number
//   of ticks each bus phase lasts; write it only while the engine is idle.
//   Reset (rst_n low, synchronous) returns the engine to idle with scl high
//   and sda released, and empties the result register.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  // tick channel
  input  logic                 in_valid,
  output logic                 in_stall,
  input  i2cbe_pkg::in_item_t  in_data,
  // result channel
  output logic                 out_valid,
  input  logic                 out_stall,
  output i2cbe_pkg::out_item_t out_data,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  i2cbe_pkg::eng_state_t state_r;
  i2cbe_pkg::eng_state_t state_nxt;
  i2cbe_pkg::out_item_t  out_data_r;
  i2cbe_pkg::out_item_t  res;
  logic                  out_valid_r;
  logic [7:0]            phase_ticks_r;
  logic                  in_acc;
  logic                  cfg_wr;

  // config register access
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == i2cbe_pkg::REG_PHASE_TICKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cbe_pkg::PHASE_TICKS_RST;
    end else if (cfg_wr) begin
      phase_ticks_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == i2cbe_pkg::REG_PHASE_TICKS) prdata = {24'd0, phase_ticks_r};
  end

  // one tick of the line engine
  i2cbe_phase u_phase (
    .cur         (state_r),
    .item        (in_data),
    .phase_ticks (phase_ticks_r),
    .nxt         (state_nxt),
    .res         (res)
  );

  // accept while the result register is free or being drained
  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  // engine state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.op    <= i2cbe_pkg::OP_IDLE;
      state_r.step  <= 3'd0;
      state_r.bits  <= 4'd0;
      state_r.hold  <= 8'd0;
      state_r.shift <= 8'd0;
      state_r.lines <= i2cbe_pkg::LINES_RELEASED;
      state_r.ack   <= 1'b0;
      state_r.rd    <= 8'd0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // idle engine keeps its phase counters cleared
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.op == i2cbe_pkg::OP_IDLE |-> state_r.step == 3'd0 && state_r.hold == 8'd0)
    else $error("idle engine with live phase counters");

  // a running phase never holds past its tick count
  a_hold_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.op != i2cbe_pkg::OP_IDLE |->
      state_r.hold != 8'd0 &&
      (state_r.hold <= phase_ticks_r || phase_ticks_r == 8'd0))
    else $error("phase hold count out of range");

  // bit counter and step stay within one byte sequence
  a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bits <= i2cbe_pkg::BYTE_BITS && state_r.step <= i2cbe_pkg::LAST_STEP)
    else $error("bit count or phase step out of range");

  // a finished sequence reports idle in the same result
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done reported while still busy");

  // state advances only with an accepted tick
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(state_r))
    else $error("engine state moved without a tick");
`endif

endmodule

>>> verif/i2c_master_bit_engine_unit_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit_tb
// Self-checking bench for the tick-driven i2c master line engine. A short
// table of directed ticks (idle outputs, unknown and ignored commands, start,
// write with acknowledge, read, stop) is followed by random bus transactions
// over several phase_ticks settings. Every result transaction is compared
// field by field against a cycle-free model of the engine kept in the bench,
// with random idling on the tick side and random stalls on the result side.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit_tb;
  import i2cbe_pkg::*;

  // reserved command codes, ignored by the engine
  localparam logic [2:0] CMD_RSVD_A = 3'd5;
  localparam logic [2:0] CMD_RSVD_B = 3'd6;
  localparam logic [2:0] CMD_RSVD_C = 3'd7;

  localparam logic [2:0] PT_ADDR = {REG_PHASE_TICKS, 2'b00};

  // bus lines and flags right after reset
  localparam out_item_t IDLE_OUT = '{scl_level: 1'b1, sda_level: 1'b1, sda_enable: 1'b0,
                                     busy_res: 1'b0, done_res: 1'b0, read_byte: 8'h00,
                                     ack_seen: 1'b0};

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] wb;
    logic       sda;
    logic [5:0] reps;    // plain ticks that follow, same sda level
    logic       typed;   // use the result typed in below
    out_item_t  want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // engine model state
  op_t        eng_op;
  logic [2:0] eng_step;
  logic [3:0] eng_bits;
  logic [7:0] eng_hold;
  logic [7:0] eng_shift;
  lines_t     eng_lines;
  logic       eng_ack;
  logic [7:0] eng_rd;
  logic [7:0] eng_ticks;

  out_item_t  bus_expect[$];
  int         errors = 0;
  int         results_seen = 0;
  int         stall_left = 0;
  int         stall_draw = 0;
  bit         calm = 1'b0;
  logic [2:0] last_cmd = CMD_TICK;

  // the longest phase setting runs last, so no flush has to wait it out
  int phase_plan [8] = '{4, 0, 2, 3, 1, 7, 1, 255};

  dir_row_t dir_rows [9] = '{
    '{cmd: CMD_TICK,   wb: 8'h00, sda: 1'b0, reps: 6'd0,  typed: 1'b1, want: IDLE_OUT},
    '{cmd: CMD_RSVD_A, wb: 8'hFF, sda: 1'b1, reps: 6'd0,  typed: 1'b1, want: IDLE_OUT},
    '{cmd: CMD_RSVD_B, wb: 8'h00, sda: 1'b0, reps: 6'd0,  typed: 1'b1, want: IDLE_OUT},
    '{cmd: CMD_RSVD_C, wb: 8'hFF, sda: 1'b1, reps: 6'd0,  typed: 1'b1, want: IDLE_OUT},
    '{cmd: CMD_START,  wb: 8'h00, sda: 1'b1, reps: 6'd0,  typed: 1'b0, want: '0},
    // read while the start is running, must be dropped
    '{cmd: CMD_READ,   wb: 8'h00, sda: 1'b1, reps: 6'd2,  typed: 1'b0, want: '0},
    '{cmd: CMD_WRITE,  wb: 8'hFF, sda: 1'b0, reps: 6'd27, typed: 1'b0, want: '0},
    '{cmd: CMD_READ,   wb: 8'h5A, sda: 1'b1, reps: 6'd20, typed: 1'b0, want: '0},
    '{cmd: CMD_STOP,   wb: 8'h00, sda: 1'b1, reps: 6'd3,  typed: 1'b0, want: '0}
  };

  i2c_master_bit_engine_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (errors < 50) $display("mismatch: %s", msg);
    errors++;
  endtask

  // line levels held during one phase of a sequence
  function automatic lines_t phase_drive(op_t op, logic [2:0] step, logic msb);
    lines_t d;
    d = '{en: 1'b1, sda: 1'b0, scl: 1'b0};
    case (op)
      OP_START: begin
        d.scl = (step < 3'd2);
        d.sda = (step == 3'd0);
      end
      OP_STOP: begin
        d.scl = (step != 3'd0);
        d.sda = (step >= 3'd2);
      end
      OP_WRITE: begin
        if (step <= 3'd2) begin
          d.sda = msb;
          d.scl = (step == 3'd1);
        end else if (step == 3'd4) begin
          d = '{en: 1'b0, sda: 1'b1, scl: 1'b1};
        end
      end
      OP_READ: begin
        if (step <= 3'd2) d = '{en: 1'b0, sda: 1'b1, scl: step == 3'd1};
        else if (step == 3'd4) d.scl = 1'b1;
      end
      default: d = eng_lines;
    endcase
    return d;
  endfunction

  function automatic void enter_phase(logic [2:0] step);
    eng_step  = step;
    eng_hold  = 8'd1;
    eng_lines = phase_drive(eng_op, step, eng_shift[7]);
  endfunction

  function automatic void reset_engine();
    eng_op    = OP_IDLE;
    eng_step  = '0;
    eng_bits  = '0;
    eng_hold  = '0;
    eng_shift = '0;
    eng_lines = LINES_RELEASED;
    eng_ack   = 1'b0;
    eng_rd    = '0;
    eng_ticks = PHASE_TICKS_RST;
  endfunction

  // advance the engine by one tick and give the bus state after it
  function automatic out_item_t engine_tick(in_item_t t);
    logic [7:0] lim;
    logic       fin;
    out_item_t  r;
    lim = (eng_ticks == 8'd0) ? 8'd1 : eng_ticks;
    fin = 1'b0;
    if (eng_op == OP_IDLE) begin
      case (t.cmd)
        CMD_START: eng_op = OP_START;
        CMD_STOP:  eng_op = OP_STOP;
        CMD_WRITE: eng_op = OP_WRITE;
        CMD_READ:  eng_op = OP_READ;
        default:   eng_op = OP_IDLE;
      endcase
      if (eng_op != OP_IDLE) begin
        eng_bits = '0;
        if (eng_op == OP_WRITE) eng_shift = t.write_byte;
        else if (eng_op == OP_READ) eng_shift = '0;
        enter_phase(3'd0);
      end
    end else if (eng_hold >= lim) begin
      case (eng_op)
        OP_START, OP_STOP: begin
          if (eng_step < 3'd2) enter_phase(eng_step + 3'd1);
          else fin = 1'b1;
        end
        OP_WRITE: begin
          if (eng_step == 3'd2) begin
            eng_shift = eng_shift << 1;
            eng_bits  = eng_bits + 4'd1;
            enter_phase(eng_bits < BYTE_BITS ? 3'd0 : 3'd3);
          end else if (eng_step == 3'd4) begin
            // acknowledge slot, sda low means acknowledged
            eng_ack = ~t.sda_in;
            enter_phase(LAST_STEP);
          end else if (eng_step >= LAST_STEP) begin
            fin = 1'b1;
          end else begin
            enter_phase(eng_step + 3'd1);
          end
        end
        OP_READ: begin
          if (eng_step == 3'd1) begin
            eng_shift = {eng_shift[6:0], t.sda_in};
            eng_bits  = eng_bits + 4'd1;
            enter_phase(3'd2);
          end else if (eng_step == 3'd2) begin
            enter_phase(eng_bits < BYTE_BITS ? 3'd1 : 3'd3);
          end else if (eng_step >= LAST_STEP) begin
            eng_rd = eng_shift;
            fin    = 1'b1;
          end else begin
            enter_phase(eng_step + 3'd1);
          end
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        if (eng_op == OP_STOP) eng_lines = LINES_RELEASED;
        eng_op   = OP_IDLE;
        eng_step = '0;
        eng_hold = '0;
      end
    end else begin
      eng_hold = eng_hold + 8'd1;
    end
    r.scl_level  = eng_lines.scl;
    r.sda_level  = eng_lines.en ? eng_lines.sda : 1'b1;
    r.sda_enable = eng_lines.en;
    r.busy_res   = (eng_op != OP_IDLE);
    r.done_res   = fin;
    r.read_byte  = eng_rd;
    r.ack_seen   = eng_ack;
    return r;
  endfunction

  // next command: mostly well-formed bus transactions, some noise
  function automatic logic [2:0] pick_cmd();
    int         r;
    logic [2:0] c;
    r = $urandom_range(0, 99);
    c = 3'($urandom_range(0, 7));
    if (eng_op != OP_IDLE) return (r < 10) ? c : CMD_TICK;
    if (r < 12) return c;
    case (last_cmd)
      CMD_START: c = CMD_WRITE;
      CMD_WRITE: c = (r < 40) ? CMD_WRITE : (r < 65) ? CMD_READ : (r < 85) ? CMD_STOP : CMD_START;
      CMD_READ:  c = (r < 60) ? CMD_READ : CMD_STOP;
      default:   c = (r < 85) ? CMD_START : CMD_TICK;
    endcase
    return c;
  endfunction

  // one tick transaction; the expectation is queued once it is accepted
  task automatic send_tick(input in_item_t t, input logic typed, input out_item_t want);
    int        gap;
    out_item_t exp_out;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_out = engine_tick(t);
    bus_expect.push_back(typed ? want : exp_out);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (bus_expect.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // run the engine back to idle so the register may change
  task automatic flush_engine();
    in_item_t t;
    calm = 1'b1;
    while (eng_op != OP_IDLE) begin
      t = '{cmd: CMD_TICK, write_byte: 8'($urandom_range(0, 255)),
            sda_in: 1'($urandom_range(0, 1))};
      send_tick(t, 1'b0, '0);
    end
    drain();
    calm = 1'b0;
  endtask

  task automatic cfg_read_check(input logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PT_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== want)
      flag_error($sformatf("phase_ticks reads %h, expected %h", prdata[7:0], want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_set(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PT_ADDR;
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    eng_ticks = v;
    cfg_read_check(v);
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d %s got %h expected %h", results_seen, name, got, want));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (bus_expect.size() == 0) begin
      flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
      return;
    end
    want = bus_expect.pop_front();
    check_field("scl_level", 8'(got.scl_level), 8'(want.scl_level));
    check_field("sda_level", 8'(got.sda_level), 8'(want.sda_level));
    check_field("sda_enable", 8'(got.sda_enable), 8'(want.sda_enable));
    check_field("busy_res", 8'(got.busy_res), 8'(want.busy_res));
    check_field("done_res", 8'(got.done_res), 8'(want.done_res));
    check_field("read_byte", got.read_byte, want.read_byte);
    check_field("ack_seen", 8'(got.ack_seen), 8'(want.ack_seen));
  endtask

  // result side: take, check, then draw a random stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      check_result(out_data);
      results_seen++;
      stall_draw = calm ? 0 : int'($urandom_range(0, 13));
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end
  end

  // main sequence
  initial begin
    in_item_t t;
    int       items_here;
    reset_engine();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    cfg_read_check(PHASE_TICKS_RST);
    cfg_set(8'd1);

    // directed table
    for (int i = 0; i < 9; i++) begin
      t = '{cmd: dir_rows[i].cmd, write_byte: dir_rows[i].wb, sda_in: dir_rows[i].sda};
      send_tick(t, dir_rows[i].typed, dir_rows[i].want);
      for (int k = 0; k < dir_rows[i].reps; k++) begin
        t = '{cmd: CMD_TICK, write_byte: 8'($urandom_range(0, 255)), sda_in: dir_rows[i].sda};
        send_tick(t, 1'b0, '0);
      end
    end

    // random bus transactions over several phase lengths
    for (int p = 0; p < 8; p++) begin
      flush_engine();
      cfg_set(8'(phase_plan[p]));
      calm = (p == 5);
      items_here = (p == 7) ? 60 : 240;
      for (int n = 0; n < items_here; n++) begin
        t.cmd        = pick_cmd();
        t.write_byte = 8'($urandom_range(0, 255));
        t.sda_in     = 1'($urandom_range(0, 1));
        if (eng_op == OP_IDLE && t.cmd >= CMD_START && t.cmd <= CMD_READ) last_cmd = t.cmd;
        send_tick(t, 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> i2c_master_bit_engine_unit.f
hdl/i2cbe_pkg.sv
hdl/i2cbe_phase.sv
hdl/i2c_master_bit_engine_unit.sv
verif/i2c_master_bit_engine_unit_tb.sv
